### rtl/ftfd_pkg.sv
// Shared constants, codes and types for the FSK tone and frame detector.
package ftfd_pkg;

  localparam int unsigned LEVEL_W         = 16;
  localparam int unsigned GAIN_FRAC       = 12;
  localparam int unsigned FRAME_BITS      = 16;
  localparam int unsigned TONE_WINDOW_DEF = 7;

  localparam logic [15:0] SYNC_MASK = 16'hF800;
  localparam logic [15:0] SYNC_WORD = 16'h7000;

  localparam logic [15:0] GAIN_RST      = 16'd5734;
  localparam logic [15:0] THRESHOLD_RST = 16'd819;
  localparam logic [15:0] RATIO_SQ_RST  = 16'd2621;
  localparam logic [7:0]  LOSS_BITS_RST = 8'd14;

  localparam int unsigned CFG_ADDR_W = 4;

  // register index, paddr[3:2]
  localparam logic [1:0] REG_GAIN      = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_RATIO_SQ  = 2'd2;
  localparam logic [1:0] REG_LOSS_BITS = 2'd3;

  // tone_event codes
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_DETECT = 2'd1;
  localparam logic [1:0] EV_LOST   = 2'd2;

  typedef struct packed {
    logic [15:0] level_gain;
    logic [15:0] level_threshold;
    logic [15:0] spread_ratio_sq;
    logic [7:0]  loss_bits;
  } cfg_t;

endpackage

### rtl/ftfd_cfg.sv
// APB configuration registers of the FSK tone and frame detector.
module ftfd_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ftfd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output ftfd_pkg::cfg_t                   cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_gain      <= ftfd_pkg::GAIN_RST;
      cfg.level_threshold <= ftfd_pkg::THRESHOLD_RST;
      cfg.spread_ratio_sq <= ftfd_pkg::RATIO_SQ_RST;
      cfg.loss_bits       <= ftfd_pkg::LOSS_BITS_RST;
    end else if (wr_en) begin
      case (reg_idx)
        ftfd_pkg::REG_GAIN:      cfg.level_gain      <= pwdata[15:0];
        ftfd_pkg::REG_THRESHOLD: cfg.level_threshold <= pwdata[15:0];
        ftfd_pkg::REG_RATIO_SQ:  cfg.spread_ratio_sq <= pwdata[15:0];
        ftfd_pkg::REG_LOSS_BITS: cfg.loss_bits       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ftfd_pkg::REG_GAIN:      prdata = {16'd0, cfg.level_gain};
      ftfd_pkg::REG_THRESHOLD: prdata = {16'd0, cfg.level_threshold};
      ftfd_pkg::REG_RATIO_SQ:  prdata = {16'd0, cfg.spread_ratio_sq};
      ftfd_pkg::REG_LOSS_BITS: prdata = {24'd0, cfg.loss_bits};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

### rtl/fsk_tone_and_frame_detector_top.sv
// Top level: FSK continuous-tone and 16-bit frame detector.
//
// Each item carries one demodulated bit and its level. The level is scaled by
// level_gain, stored in a tone window of TONE_WINDOW levels and a frame window
// of 16 levels, and both windows are then checked for threshold and level
// spread by a shared multiplier stepped by a small sequencer, plus a multiply
// by the constant window length. From acceptance until s_tready returns, the
// sequencer scales and stores the level, then for each of the two windows
// steps through the window entries and the spread arithmetic (drain, square,
// N*Q, ratio high, compare), and last forms the result. s_tready is high
// only while the sequencer is idle. One result item comes out per input item
// and is held in an output register, so the next item is accepted while the
// result waits; the sequencer stalls in its last state for as long as the
// previous result is still unaccepted. Configuration registers are read while
// an item is processed, so a write takes effect at once, also mid-item.
module fsk_tone_and_frame_detector_top #(
  parameter int unsigned TONE_WINDOW = ftfd_pkg::TONE_WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input item
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [23:0]                     s_tdata,  // rx_bit, raw_level[15:0], zero pad
  // result item
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [23:0]                     m_tdata,  // tone_event[1:0], tone_value,
                                                    // frame_valid, frame_word[15:0], pad
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ftfd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int unsigned FB    = ftfd_pkg::FRAME_BITS;
  localparam int unsigned NMAX  = (TONE_WINDOW > FB) ? TONE_WINDOW : FB;
  localparam int unsigned IDX_W = $clog2(NMAX);
  localparam int unsigned TP_W  = $clog2(TONE_WINDOW);
  localparam int unsigned FP_W  = $clog2(FB);
  localparam int unsigned LW    = ftfd_pkg::LEVEL_W;
  localparam int unsigned S_W   = LW + $clog2(NMAX);  // window sum
  localparam int unsigned Q_W   = S_W + LW;           // window sum of squares
  localparam int unsigned V_W   = 2 * S_W;            // product / variance term
  localparam int unsigned R_W   = V_W + 16;           // compare width

  typedef enum logic [3:0] {
    ST_IDLE, ST_GAIN, ST_STORE, ST_ELEM, ST_DRAIN,
    ST_SQR, ST_NQ, ST_RHI, ST_CMP, ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    HELD_NONE = 2'd0,
    HELD_F0   = 2'd1,
    HELD_F1   = 2'd2
  } held_t;

  ftfd_pkg::cfg_t cfg;

  ftfd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  state_t               state;
  logic                 bit_q;
  logic [LW-1:0]        raw_q;
  logic [V_W-1:0]       mp;
  logic [LW-1:0]        tone_levels [TONE_WINDOW];
  logic [LW-1:0]        frame_levels [FB];
  logic [TP_W-1:0]      tpos;
  logic [FP_W-1:0]      fpos;
  logic [TONE_WINDOW-1:0] tone_bits;
  logic [FB-1:0]        frame_bits;
  logic                 win;       // 0 tone window, 1 frame window
  logic [IDX_W-1:0]     idx;
  logic [S_W-1:0]       sum;
  logic [Q_W-1:0]       sumsq;
  logic                 fail;
  logic [V_W-1:0]       var_q;
  logic [S_W-1:0]       ss_hi;
  logic [V_W-1:0]       rlo;
  logic                 tone_ok;
  logic                 frame_ok;
  held_t                held;
  logic [7:0]           bad_count;
  logic [1:0]           tone_event;
  logic                 tone_value;
  logic                 frame_valid;
  logic [FB-1:0]        frame_word;

  // shared multiplier operands
  logic [S_W-1:0]       mul_a;
  logic [S_W-1:0]       mul_b;
  logic [V_W-1:0]       mul_p;

  logic [LW-1:0]        lvl;
  logic [LW-1:0]        cur_v;
  logic                 last_idx;
  logic [V_W-1:0]       nq;
  logic [V_W-1:0]       var_d;
  logic [R_W-1:0]       lhs;
  logic [R_W-1:0]       rhs;
  logic                 win_ok;
  logic                 out_load;
  logic                 tone_match;
  logic                 good;
  logic [7:0]           bad_inc;
  held_t                held_bit;
  logic [1:0]           ev_d;

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {4'd0, frame_word, frame_valid, tone_value, tone_event};

  always_comb begin
    case (state)
      ST_GAIN: begin
        mul_a = S_W'(raw_q);
        mul_b = S_W'(cfg.level_gain);
      end
      ST_ELEM: begin
        mul_a = S_W'(cur_v);
        mul_b = S_W'(cur_v);
      end
      ST_SQR: begin
        mul_a = sum;
        mul_b = sum;
      end
      ST_NQ: begin
        mul_a = mp[S_W-1:0];
        mul_b = S_W'(cfg.spread_ratio_sq);
      end
      ST_RHI: begin
        mul_a = ss_hi;
        mul_b = S_W'(cfg.spread_ratio_sq);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // normalized level, saturated to 16 bits
  assign lvl = (|mp[V_W-1:LW+ftfd_pkg::GAIN_FRAC]) ? {LW{1'b1}}
             : mp[LW+ftfd_pkg::GAIN_FRAC-1:ftfd_pkg::GAIN_FRAC];

  assign cur_v    = win ? frame_levels[idx[FP_W-1:0]] : tone_levels[idx[TP_W-1:0]];
  assign last_idx = win ? (idx == IDX_W'(FB - 1)) : (idx == IDX_W'(TONE_WINDOW - 1));

  // N*Q by a constant window length; mp holds S*S in this step
  assign nq    = win ? (V_W'(sumsq) * V_W'(FB)) : (V_W'(sumsq) * V_W'(TONE_WINDOW));
  assign var_d = (nq >= mp) ? (nq - mp) : '0;

  assign lhs    = R_W'(var_q) << 16;
  assign rhs    = (R_W'(mp) << S_W) + R_W'(rlo);
  assign win_ok = !fail && !(lhs > rhs);

  assign out_load   = (state == ST_DONE) && (!m_tvalid || m_tready);
  assign tone_match = bit_q ? (&tone_bits) : ~(|tone_bits);
  assign good       = tone_match && tone_ok;
  assign bad_inc    = bad_count + 8'd1;
  assign held_bit   = bit_q ? HELD_F1 : HELD_F0;

  always_comb begin
    ev_d = ftfd_pkg::EV_NONE;
    if (good) begin
      if (held != held_bit) ev_d = ftfd_pkg::EV_DETECT;
    end else if (held != HELD_NONE && bad_inc == cfg.loss_bits) begin
      ev_d = ftfd_pkg::EV_LOST;
    end
  end

  always_ff @(posedge clk) begin
    mp <= mul_p;
    if (rst) begin
      state      <= ST_IDLE;
      tpos       <= '0;
      fpos       <= '0;
      tone_bits  <= '0;
      frame_bits <= '0;
      held       <= HELD_NONE;
      bad_count  <= '0;
      m_tvalid   <= 1'b0;
      for (int i = 0; i < int'(TONE_WINDOW); i++) tone_levels[i] <= '0;
      for (int i = 0; i < int'(FB); i++) frame_levels[i] <= '0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            bit_q <= s_tdata[0];
            raw_q <= s_tdata[16:1];
            state <= ST_GAIN;
          end
        end
        ST_GAIN: state <= ST_STORE;
        ST_STORE: begin
          tone_levels[tpos]  <= lvl;
          frame_levels[fpos] <= lvl;
          tpos       <= (tpos == TP_W'(TONE_WINDOW - 1)) ? '0 : tpos + TP_W'(1);
          fpos       <= fpos + FP_W'(1);
          tone_bits  <= {tone_bits[TONE_WINDOW-2:0], bit_q};
          frame_bits <= {frame_bits[FB-2:0], bit_q};
          win   <= 1'b0;
          idx   <= '0;
          sum   <= '0;
          sumsq <= '0;
          fail  <= 1'b0;
          state <= ST_ELEM;
        end
        ST_ELEM: begin
          if (cur_v < cfg.level_threshold) fail <= 1'b1;
          sum <= sum + S_W'(cur_v);
          // mp holds the square of the previous entry
          if (idx != '0) sumsq <= sumsq + Q_W'(mp);
          idx <= idx + IDX_W'(1);
          if (last_idx) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          sumsq <= sumsq + Q_W'(mp);
          state <= ST_SQR;
        end
        ST_SQR: state <= ST_NQ;
        ST_NQ: begin
          var_q <= var_d;
          ss_hi <= mp[V_W-1:S_W];
          state <= ST_RHI;
        end
        ST_RHI: begin
          rlo   <= mp;
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (!win) begin
            tone_ok <= win_ok;
            win     <= 1'b1;
            idx     <= '0;
            sum     <= '0;
            sumsq   <= '0;
            fail    <= 1'b0;
            state   <= ST_ELEM;
          end else begin
            frame_ok <= win_ok;
            state    <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            if (good) begin
              bad_count <= '0;
              held      <= held_bit;
            end else if (held != HELD_NONE) begin
              bad_count <= bad_inc;
              if (bad_inc == cfg.loss_bits) held <= HELD_NONE;
            end
            tone_event  <= ev_d;
            tone_value  <= (ev_d == ftfd_pkg::EV_DETECT) ? bit_q : 1'b0;
            frame_valid <= ((frame_bits & ftfd_pkg::SYNC_MASK) == ftfd_pkg::SYNC_WORD)
                           && frame_ok;
            frame_word  <= frame_bits;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a new item is never taken back to back
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item accepted while sequencer busy");

  // a reported frame always carries the sync pattern
  a_frame_sync: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[3]) |-> (m_tdata[19:15] == 5'b01110))
    else $error("frame reported without sync pattern");

  // a loss event drops the held tone
  a_loss_clears: assert property (@(posedge clk) disable iff (rst)
    (out_load && ev_d == ftfd_pkg::EV_LOST) |=> (held == HELD_NONE))
    else $error("tone loss did not clear held tone");

  // a detection leaves the detected tone held
  a_detect_holds: assert property (@(posedge clk) disable iff (rst)
    (out_load && ev_d == ftfd_pkg::EV_DETECT) |=> (held != HELD_NONE && tone_value == bit_q))
    else $error("tone detection not held");

endmodule
